@@ rtl/iorsh_pkg.sv @@
// ----------------------------------------------------------------------------
// iorsh_pkg
// shared constants, codes and types of the in-order release block
// ----------------------------------------------------------------------------
package iorsh_pkg;

  localparam int HOLD_DEPTH = 32;
  localparam int ID_BITS    = 16;
  localparam int VAL_BITS   = 16;
  localparam int CNT_BITS   = $clog2(HOLD_DEPTH + 1);

  localparam logic [ID_BITS-1:0] START_RESET = ID_BITS'(1);

  typedef enum logic [1:0] {
    KIND_INPUT  = 2'd0,
    KIND_HOLD   = 2'd1,
    KIND_REJECT = 2'd2,
    KIND_END    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [ID_BITS-1:0] car_id;
    logic               is_last;
  } item_t;

  typedef struct packed {
    kind_e               kind;
    logic [VAL_BITS-1:0] value;
    logic                last_result;
  } result_t;

  typedef struct packed {
    logic               ins;
    logic               pop;
    logic [ID_BITS-1:0] id;
  } hold_cmd_t;

  typedef struct packed {
    logic [CNT_BITS-1:0] count;
    logic [ID_BITS-1:0]  head;
    logic [ID_BITS-1:0]  second;
  } hold_stat_t;

endpackage

@@ rtl/in_order_release_sorted_hold.sv @@
// ----------------------------------------------------------------------------
// in_order_release_sorted_hold
// Numbered items enter through a queue interface and leave in ascending
// order from the start number. A two-entry input queue feeds a sequencer
// that owns the expected number and a sorted hold store built as a chain of
// 32 cells; results go out through a two-entry result queue. The sequencer
// writes at most one result per cycle: a matching or rejected item writes its
// own result in the cycle in which it is taken, each held item released
// after it writes one result in turn, and an item with a last mark is
// followed by an end record; a full result queue stalls the sequencer. A
// sorted insert or a head removal updates the cell chain in place. No
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module in_order_release_sorted_hold (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [iorsh_pkg::ID_BITS-1:0]  car_id_i,
  input  logic                           is_last_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [1:0]                     kind_o,
  output logic [iorsh_pkg::VAL_BITS-1:0] value_o,
  output logic                           last_result_o,
  input  logic                           cfg_we_i,
  input  logic [iorsh_pkg::ID_BITS-1:0]  cfg_data_i
);

  iorsh_pkg::item_t      in_item, front_item;
  logic                  front_valid, take;
  iorsh_pkg::hold_cmd_t  hold_cmd;
  iorsh_pkg::hold_stat_t hold_stat;
  logic                  out_full, emit;
  iorsh_pkg::result_t    result, out_result;

  assign in_item = '{car_id: car_id_i, is_last: is_last_i};

  iorsh_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .item_i  (in_item),
    .valid_o (front_valid),
    .item_o  (front_item),
    .take_i  (take)
  );

  iorsh_hold u_hold (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (hold_cmd),
    .stat_o (hold_stat)
  );

  iorsh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (front_valid),
    .item_i      (front_item),
    .take_o      (take),
    .hold_cmd_o  (hold_cmd),
    .hold_stat_i (hold_stat),
    .out_full_i  (out_full),
    .emit_o      (emit),
    .result_o    (result)
  );

  iorsh_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .emit_i   (emit),
    .result_i (result),
    .full_o   (out_full),
    .empty    (empty),
    .pop      (pop),
    .result_o (out_result)
  );

  assign kind_o        = out_result.kind;
  assign value_o       = out_result.value;
  assign last_result_o = out_result.last_result;

endmodule

@@ rtl/iorsh_front.sv @@
// ----------------------------------------------------------------------------
// iorsh_front
// two-entry input queue between the push side and the sequencer
// ----------------------------------------------------------------------------
module iorsh_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  iorsh_pkg::item_t item_i,
  output logic             valid_o,
  output iorsh_pkg::item_t item_o,
  input  logic             take_i
);

  iorsh_pkg::item_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_en, rd_en;

  assign full    = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];
  assign wr_en   = push && !full;
  assign rd_en   = take_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ wr_en;
    rd_ptr_d = rd_ptr_q ^ rd_en;
    cnt_d    = cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ rtl/iorsh_hold.sv @@
// ----------------------------------------------------------------------------
// iorsh_hold
// sorted hold store as a chain of cells, smallest at the head
// ----------------------------------------------------------------------------
module iorsh_hold (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  iorsh_pkg::hold_cmd_t  cmd_i,
  output iorsh_pkg::hold_stat_t stat_o
);

  logic [iorsh_pkg::ID_BITS-1:0]  hold_q [iorsh_pkg::HOLD_DEPTH];
  logic [iorsh_pkg::CNT_BITS-1:0] count_q, count_d;
  logic [iorsh_pkg::HOLD_DEPTH-1:0] at_pos;

  // cell at or past the insert point
  always_comb begin
    for (int i = 0; i < iorsh_pkg::HOLD_DEPTH; i++) begin
      at_pos[i] = (iorsh_pkg::CNT_BITS'(i) >= count_q) || (hold_q[i] > cmd_i.id);
    end
  end

  always_comb begin
    stat_o.count  = count_q;
    stat_o.head   = hold_q[0];
    stat_o.second = hold_q[0];
    for (int i = 0; i < iorsh_pkg::HOLD_DEPTH; i++) begin
      if (i == 1) begin
        stat_o.second = hold_q[i];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.ins) begin
      count_d = count_q + iorsh_pkg::CNT_BITS'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - iorsh_pkg::CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  for (genvar g = 0; g < iorsh_pkg::HOLD_DEPTH; g++) begin : g_cell
    logic [iorsh_pkg::ID_BITS-1:0] ins_val;
    logic [iorsh_pkg::ID_BITS-1:0] pop_val;

    if (g == 0) begin : g_first
      assign ins_val = cmd_i.id;
    end else begin : g_rest
      assign ins_val = at_pos[g-1] ? hold_q[g-1] : cmd_i.id;
    end

    if (g + 1 < iorsh_pkg::HOLD_DEPTH) begin : g_shift
      assign pop_val = hold_q[g+1];
    end else begin : g_tail
      assign pop_val = hold_q[g];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.ins) begin
        if (at_pos[g]) begin
          hold_q[g] <= ins_val;
        end
      end else if (cmd_i.pop) begin
        hold_q[g] <= pop_val;
      end
    end
  end

endmodule

@@ rtl/iorsh_ctrl.sv @@
// ----------------------------------------------------------------------------
// iorsh_ctrl
// sequencer: matches items against the expected number, drives the hold
// store and, unless the result queue is full, emits at most one result per cycle
// ----------------------------------------------------------------------------
module iorsh_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [iorsh_pkg::ID_BITS-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  input  iorsh_pkg::item_t              item_i,
  output logic                          take_o,
  output iorsh_pkg::hold_cmd_t          hold_cmd_o,
  input  iorsh_pkg::hold_stat_t         hold_stat_i,
  input  logic                          out_full_i,
  output logic                          emit_o,
  output iorsh_pkg::result_t            result_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_END  = 2'd2;

  logic [1:0]                    state_q, state_d;
  logic                          is_last_q, is_last_d;
  logic [iorsh_pkg::ID_BITS-1:0] exp_q, exp_d, exp_inc;
  logic                          chain;

  assign exp_inc = exp_q + iorsh_pkg::ID_BITS'(1);

  always_comb begin
    state_d    = state_q;
    is_last_d  = is_last_q;
    exp_d      = exp_q;
    take_o     = 1'b0;
    emit_o     = 1'b0;
    hold_cmd_o = '{ins: 1'b0, pop: 1'b0, id: item_i.car_id};
    result_o   = '{kind: iorsh_pkg::KIND_INPUT, value: item_i.car_id, last_result: 1'b0};
    chain      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !out_full_i) begin
          take_o    = 1'b1;
          is_last_d = item_i.is_last;
          state_d   = item_i.is_last ? ST_END : ST_IDLE;
          if (item_i.car_id == exp_q) begin
            chain  = (hold_stat_i.count != '0) && (hold_stat_i.head == exp_inc);
            emit_o = 1'b1;
            result_o.last_result = !item_i.is_last && !chain;
            exp_d  = exp_inc;
            if (chain) begin
              state_d = ST_RUN;
            end
          end else if (hold_stat_i.count !=
                       iorsh_pkg::CNT_BITS'(iorsh_pkg::HOLD_DEPTH)) begin
            hold_cmd_o.ins = 1'b1;
          end else begin
            emit_o = 1'b1;
            result_o.kind        = iorsh_pkg::KIND_REJECT;
            result_o.last_result = !item_i.is_last;
          end
        end
      end
      ST_RUN: begin
        if (!out_full_i) begin
          chain = (hold_stat_i.count > iorsh_pkg::CNT_BITS'(1)) &&
                  (hold_stat_i.second == exp_inc);
          emit_o         = 1'b1;
          hold_cmd_o.pop = 1'b1;
          result_o.kind        = iorsh_pkg::KIND_HOLD;
          result_o.value       = hold_stat_i.head;
          result_o.last_result = !is_last_q && !chain;
          exp_d = exp_inc;
          if (!chain) begin
            state_d = is_last_q ? ST_END : ST_IDLE;
          end
        end
      end
      ST_END: begin
        if (!out_full_i) begin
          emit_o = 1'b1;
          result_o.kind        = iorsh_pkg::KIND_END;
          result_o.value       = iorsh_pkg::VAL_BITS'(hold_stat_i.count);
          result_o.last_result = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (cfg_we_i) begin
      exp_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      is_last_q <= 1'b0;
      exp_q     <= iorsh_pkg::START_RESET;
    end else begin
      state_q   <= state_d;
      is_last_q <= is_last_d;
      exp_q     <= exp_d;
    end
  end

endmodule

@@ rtl/iorsh_outq.sv @@
// ----------------------------------------------------------------------------
// iorsh_outq
// two-entry result queue toward the pop side
// ----------------------------------------------------------------------------
module iorsh_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               emit_i,
  input  iorsh_pkg::result_t result_i,
  output logic               full_o,
  output logic               empty,
  input  logic               pop,
  output iorsh_pkg::result_t result_o
);

  iorsh_pkg::result_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_en, rd_en;

  assign full_o   = (cnt_q == 2'd2);
  assign empty    = (cnt_q == 2'd0);
  assign result_o = mem_q[rd_ptr_q];
  assign wr_en    = emit_i && !full_o;
  assign rd_en    = pop && !empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ wr_en;
    rd_ptr_d = rd_ptr_q ^ rd_en;
    cnt_d    = cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= result_i;
    end
  end

endmodule

@@ rtl/iorsh_check.sv @@
// ----------------------------------------------------------------------------
// iorsh_check
// port-level checks of the in-order release block, bound to the top level
// ----------------------------------------------------------------------------
module iorsh_check (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           full,
  input logic                           empty,
  input logic                           pop,
  input logic [1:0]                     kind_o,
  input logic [iorsh_pkg::VAL_BITS-1:0] value_o,
  input logic                           last_result_o
);

  // queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> (empty && !full))
    else $error("queues not empty during reset");

  // a waiting result transaction holds until popped
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(kind_o) && $stable(value_o)
                          && $stable(last_result_o)))
    else $error("waiting result changed");

  // an end record always closes the results of its item
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == iorsh_pkg::KIND_END) |-> last_result_o)
    else $error("end record without last mark");

  // held count in an end record never exceeds the store size
  a_end_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == iorsh_pkg::KIND_END)
      |-> (value_o <= iorsh_pkg::VAL_BITS'(iorsh_pkg::HOLD_DEPTH)))
    else $error("end record count out of range");

endmodule

bind in_order_release_sorted_hold iorsh_check u_check (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .kind_o        (kind_o),
  .value_o       (value_o),
  .last_result_o (last_result_o)
);
